// ===== design/mbp_pkg.sv =====
// Shared types and constants for the MP4 box boundary parser.
`default_nettype none
package mbp_pkg;

   localparam int unsigned DataWidth = 8;
   localparam int unsigned RespWidth = 32;
   localparam int unsigned TypeWidth = 32;
   localparam int unsigned SizeWidth = 64;
   localparam int unsigned IdxWidth  = 5;
   localparam int unsigned HlenWidth = 6;

   localparam logic [TypeWidth-1:0] TypeUuid = 32'h7575_6964;
   localparam logic [TypeWidth-1:0] TypeMdat = 32'h6d64_6174;

   localparam logic [HlenWidth-1:0] HdrLenBase  = 6'd8;
   localparam logic [HlenWidth-1:0] LargeExtLen = 6'd8;
   localparam logic [HlenWidth-1:0] UuidExtLen  = 6'd16;

   typedef enum logic {
      PHASE_HEADER = 1'b0,
      PHASE_BODY   = 1'b1
   } phase_type;

   typedef struct packed {
      logic [DataWidth-1:0] data_byte;
      logic [RespWidth-1:0] response_remaining;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] data_out;
      logic                 in_header;
      logic [TypeWidth-1:0] box_type;
      logic                 media_data;
      logic                 box_last_byte;
      logic                 size_error;
   } rsp_type;

endpackage
`default_nettype wire

// ===== design/mbp_in_reg.sv =====
// Input register stage that holds one request until the parser takes it.
`default_nettype none
module mbp_in_reg (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire mbp_pkg::req_type req_in,
   input  wire logic           advance,
   output logic                held_valid,
   output mbp_pkg::req_type    held_req
);

   logic             valid_ff;
   logic             valid_in;
   mbp_pkg::req_type req_ff;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_in;
      end
   end

   assign held_valid = valid_ff;
   assign held_req   = req_ff;

endmodule
`default_nettype wire

// ===== design/mbp_core.sv =====
// Box header parser state and the per-byte tagging logic.
`default_nettype none
module mbp_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire mbp_pkg::req_type req,
   output mbp_pkg::rsp_type      rsp
);

   localparam logic [mbp_pkg::IdxWidth-1:0] IdxFirst     = 5'd0;
   localparam logic [mbp_pkg::IdxWidth-1:0] IdxTypeStart = 5'd4;
   localparam logic [mbp_pkg::IdxWidth-1:0] IdxTypeEnd   = 5'd7;
   localparam logic [mbp_pkg::IdxWidth-1:0] IdxLargeFrst = 5'd8;
   localparam logic [mbp_pkg::IdxWidth-1:0] IdxLargeEnd  = 5'd15;

   mbp_pkg::phase_type                   phase_ff, phase_in;
   logic [mbp_pkg::IdxWidth-1:0]         count_ff, count_in;
   logic [mbp_pkg::SizeWidth-1:0]        size_ff, size_in;
   logic [mbp_pkg::TypeWidth-1:0]        type_ff, type_in;
   logic [mbp_pkg::SizeWidth-1:0]        body_ff, body_in;
   logic                                 to_end_ff, to_end_in;
   logic                                 large_ff, large_in;

   logic [mbp_pkg::DataWidth-1:0]        b;
   logic [mbp_pkg::HlenWidth-1:0]        hlen;
   logic                                 size_lt;
   logic                                 size_is_zero;
   logic                                 size_is_one;
   logic                                 at_type_end;
   logic                                 at_large_end;
   logic                                 err;
   logic                                 finish;
   logic                                 to_end_eff;
   logic [mbp_pkg::SizeWidth-1:0]        body_len;
   logic                                 body_zero;
   logic                                 body_done;

   assign b = req.data_byte;

   // Header byte accumulation: size bytes, type bytes, then the largesize.
   always_comb begin
      size_in = size_ff;
      type_in = type_ff;
      if (phase_ff == mbp_pkg::PHASE_HEADER) begin
         if (count_ff == IdxFirst) begin
            size_in = {{(mbp_pkg::SizeWidth-mbp_pkg::DataWidth){1'b0}}, b};
            type_in = '0;
         end else if (count_ff < IdxTypeStart) begin
            size_in = {32'd0, size_ff[23:0], b};
         end else if (count_ff <= IdxTypeEnd) begin
            type_in = {type_ff[23:0], b};
         end else if (large_ff && count_ff == IdxLargeFrst) begin
            size_in = {{(mbp_pkg::SizeWidth-mbp_pkg::DataWidth){1'b0}}, b};
         end else if (large_ff && count_ff <= IdxLargeEnd) begin
            size_in = {size_ff[55:0], b};
         end
      end
   end

   // Header length and the end-of-header decisions.
   always_comb begin
      hlen = mbp_pkg::HdrLenBase
           + (large_ff ? mbp_pkg::LargeExtLen : '0)
           + ((type_in == mbp_pkg::TypeUuid) ? mbp_pkg::UuidExtLen : '0);
      size_lt      = size_in < {{(mbp_pkg::SizeWidth-mbp_pkg::HlenWidth){1'b0}}, hlen};
      size_is_zero = size_in == '0;
      size_is_one  = size_in == {{(mbp_pkg::SizeWidth-1){1'b0}}, 1'b1};
      at_type_end  = count_ff == IdxTypeEnd;
      at_large_end = large_ff && count_ff == IdxLargeEnd;
      err = (at_type_end && !size_is_one && !size_is_zero && size_lt)
         || (at_large_end && size_lt);
      finish = !err && (
            (at_type_end && !size_is_one && hlen == mbp_pkg::HdrLenBase)
         || (at_large_end && hlen == (mbp_pkg::HdrLenBase + mbp_pkg::LargeExtLen))
         || (count_ff > IdxTypeEnd && !at_large_end
             && {1'b0, count_ff} == hlen - 6'd1));
      to_end_eff = to_end_ff || (at_type_end && size_is_zero);
      if (to_end_eff) begin
         // A size-zero box runs to the end of the response, excluding this byte.
         if (req.response_remaining == '0) begin
            body_len = '0;
         end else begin
            body_len = {32'd0, req.response_remaining - 32'd1};
         end
      end else begin
         body_len = size_in - {{(mbp_pkg::SizeWidth-mbp_pkg::HlenWidth){1'b0}}, hlen};
      end
      body_zero = body_len == '0;
      body_done = body_ff == {{(mbp_pkg::SizeWidth-1){1'b0}}, 1'b1};
   end

   // Next state.
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      body_in   = body_ff;
      to_end_in = to_end_ff;
      large_in  = large_ff;
      unique case (phase_ff)
         mbp_pkg::PHASE_HEADER: begin
            if (err || (finish && body_zero)) begin
               phase_in  = mbp_pkg::PHASE_HEADER;
               count_in  = '0;
               body_in   = '0;
               to_end_in = 1'b0;
               large_in  = 1'b0;
            end else if (finish) begin
               phase_in  = mbp_pkg::PHASE_BODY;
               body_in   = body_len;
               to_end_in = to_end_eff;
            end else begin
               count_in  = count_ff + 5'd1;
               to_end_in = to_end_eff;
               large_in  = large_ff || (at_type_end && size_is_one);
            end
         end
         mbp_pkg::PHASE_BODY: begin
            body_in = body_ff - 64'd1;
            if (body_done) begin
               phase_in  = mbp_pkg::PHASE_HEADER;
               count_in  = '0;
               body_in   = '0;
               to_end_in = 1'b0;
               large_in  = 1'b0;
            end
         end
         default: begin
            phase_in = mbp_pkg::PHASE_HEADER;
         end
      endcase
   end

   // Result tags for this byte.
   always_comb begin
      rsp.data_out   = b;
      rsp.in_header  = phase_ff == mbp_pkg::PHASE_HEADER;
      rsp.box_type   = type_in;
      rsp.media_data = (phase_ff == mbp_pkg::PHASE_BODY) && (type_ff == mbp_pkg::TypeMdat);
      rsp.size_error = (phase_ff == mbp_pkg::PHASE_HEADER) && err;
      if (phase_ff == mbp_pkg::PHASE_HEADER) begin
         rsp.box_last_byte = err || (finish && body_zero);
      end else begin
         rsp.box_last_byte = body_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= mbp_pkg::PHASE_HEADER;
         count_ff  <= '0;
         size_ff   <= '0;
         type_ff   <= '0;
         body_ff   <= '0;
         to_end_ff <= 1'b0;
         large_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         size_ff   <= size_in;
         type_ff   <= type_in;
         body_ff   <= body_in;
         to_end_ff <= to_end_in;
         large_ff  <= large_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/mbp_out_reg.sv =====
// Result register that holds one tagged byte until the consumer takes it.
`default_nettype none
module mbp_out_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire mbp_pkg::rsp_type rsp_in,
   output logic                  free,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mbp_pkg::rsp_type      rsp_out
);

   logic             valid_ff;
   logic             valid_in;
   mbp_pkg::rsp_type rsp_ff;

   // The register can be reloaded in the same cycle that its content leaves.
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out   = rsp_ff;

endmodule
`default_nettype wire

// ===== design/mp4_box_boundary_parser_unit.sv =====
// A request is captured in the input register when accepted, moves into the result register
// when that register is free, and is then presented on rsp_valid until the consumer takes it.
// Throughput: one byte per cycle while rsp_ready is high; the box state advances as each byte
// moves from the input register to the result register; a held response stalls requests.
// Reset (synchronous, active high) empties both registers and returns the parser to
// the first byte of a box header with all counters cleared.
`default_nettype none
module mp4_box_boundary_parser_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [31:0] req_response_remaining,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_data_out,
   output logic             rsp_in_header,
   output logic [31:0]      rsp_box_type,
   output logic             rsp_media_data,
   output logic             rsp_box_last_byte,
   output logic             rsp_size_error
);

   mbp_pkg::req_type req_bundle;
   mbp_pkg::req_type held_req;
   mbp_pkg::rsp_type core_rsp;
   mbp_pkg::rsp_type out_rsp;
   logic             held_valid;
   logic             out_free;
   logic             step_en;

   assign req_bundle.data_byte          = req_data_byte;
   assign req_bundle.response_remaining = req_response_remaining;

   assign step_en = held_valid && out_free;

   mbp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_in     (req_bundle),
      .advance    (out_free),
      .held_valid (held_valid),
      .held_req   (held_req)
   );

   mbp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req     (held_req),
      .rsp     (core_rsp)
   );

   mbp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (held_valid),
      .rsp_in    (core_rsp),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_out   (out_rsp)
   );

   assign rsp_data_out      = out_rsp.data_out;
   assign rsp_in_header     = out_rsp.in_header;
   assign rsp_box_type      = out_rsp.box_type;
   assign rsp_media_data    = out_rsp.media_data;
   assign rsp_box_last_byte = out_rsp.box_last_byte;
   assign rsp_size_error    = out_rsp.size_error;

endmodule
`default_nettype wire

// ===== design/mbp_checker.sv =====
// Port-level checks for the MP4 box boundary parser and their binding.
`default_nettype none
module mbp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_data_out,
   input wire logic        rsp_in_header,
   input wire logic        rsp_media_data,
   input wire logic        rsp_box_last_byte,
   input wire logic        rsp_size_error
);

   // A stalled response keeps its byte and its box-last-byte tag.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out)
         && $stable(rsp_box_last_byte))
      else $error("stalled response changed");

   // A size error always closes the box on a header byte.
   a_err_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_size_error |-> rsp_box_last_byte && rsp_in_header)
      else $error("size error without box end");

   // Media data is only ever tagged on body bytes.
   a_mdat_body: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_media_data |-> !rsp_in_header)
      else $error("media data tag on a header byte");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   // Without any request in flight the input side must be ready.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      $past(!req_valid) && !rsp_valid && $past(!rsp_valid) |-> req_ready)
      else $error("request side stalled while empty");

endmodule

bind mp4_box_boundary_parser_unit mbp_checker u_mbp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_data_out      (rsp_data_out),
   .rsp_in_header     (rsp_in_header),
   .rsp_media_data    (rsp_media_data),
   .rsp_box_last_byte (rsp_box_last_byte),
   .rsp_size_error    (rsp_size_error)
);
`default_nettype wire
